// ===== src/corner_response_stream_defines.svh =====
// Assertion macros for the corner response stream block.
`ifndef CORNER_RESPONSE_STREAM_DEFINES_SVH
`define CORNER_RESPONSE_STREAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CRS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/crs_pkg.sv =====
// Shared types, widths and constants of the corner response stream block.
`default_nettype none

package crs_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COLO_W     = 10;
    localparam int RESP_W     = 54;
    localparam int SENS_W     = 16;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_WINDOW_RADIUS = 1;

    localparam logic [SENS_W-1:0] SENS_RESET = 16'd2621;
    localparam logic [FW_W-1:0]   FW_RESET   = 11'd1024;
    localparam logic [FH_W-1:0]   FH_RESET   = 13'd768;

    // Size compares run at this width (holds 4096 and every register value)
    localparam int SIZE_W     = 14;
    localparam int MIN_SIZE   = 8;
    localparam int MAX_HEIGHT = 4096;

    // Gray conversion, Q14 weights
    localparam int GRAY_SUM_W  = 22;
    localparam int GRAY_SHIFT  = 14;
    localparam int W_BLUE      = 1868;
    localparam int W_GREEN     = 9617;
    localparam int W_RED       = 4899;
    localparam int GRAY_ROUND  = 8192;

    // Datapath widths, sized for the largest window radius
    localparam int GRAD_W = 11;
    localparam int PROD_W = 21;
    localparam int CSUM_W = 24;
    localparam int MAG_W  = 26;
    localparam int WSUM_W = MAG_W + 1;
    localparam int TR_W   = MAG_W + 1;
    localparam int SQ_W   = 2 * TR_W;
    localparam int DET_W  = SQ_W + 2;
    localparam int KA_W   = SENS_W + SQ_W - 16;
    localparam int KB_W   = SENS_W + 16;
    localparam int KTT_W  = KA_W + 1;
    localparam int DIFF_W = KTT_W + 2;

    localparam logic [RESP_W-1:0] RESP_MAX = {RESP_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSITIVITY  = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0]  center_row;
        logic [COLO_W-1:0] center_column;
        logic [RESP_W-1:0] response;
        logic              frame_done;
    } result_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] xy;
    } prod_t;

endpackage

`default_nettype wire

// ===== src/crs_stream_if.sv =====
// Valid/ready channel interfaces for pixels in and responses out.
`default_nettype none

interface crs_pixel_if;
    logic            valid;
    logic            ready;
    crs_pkg::pixel_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crs_result_if;
    logic             valid;
    logic             ready;
    crs_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/corner_response_stream.sv =====
// Harris corner response over a raster pixel stream, line memories and column sums.
// Pixels are taken only in S_IDLE, so one pixel's work, and its response when one is
//   made, ends before the next is accepted; back-pressure on the output holds S_OUT.
// A response passes READ, GRAD, PROD, COLW, a WRD/WACC pair per window column, MUL,
//   SQR, KMUL, KSUM, DIFF and OUT, where it loads the output register.
// Reset: counters, state and config clear at once; datapath regs and line memories do not.
`default_nettype none

`include "corner_response_stream_defines.svh"

module corner_response_stream #(
    parameter int MAX_WIDTH     = crs_pkg::DEF_MAX_WIDTH,
    parameter int WINDOW_RADIUS = crs_pkg::DEF_WINDOW_RADIUS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    crs_pixel_if.sink                           pixel,
    crs_result_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int SIDE      = 2 * WINDOW_RADIUS + 1;
    localparam int PROD_ROWS = 2 * WINDOW_RADIUS;
    localparam int IDX_W     = $clog2(SIDE + 1);
    localparam int SW        = crs_pkg::SIZE_W;

    // One word per column: products of the last gradient rows plus the column sums
    typedef struct packed {
        crs_pkg::prod_t [PROD_ROWS-1:0]     rows;
        logic signed [crs_pkg::CSUM_W-1:0] sxx;
        logic signed [crs_pkg::CSUM_W-1:0] syy;
        logic signed [crs_pkg::CSUM_W-1:0] sxy;
    } col_word_t;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_READ = 13'b0000000000010,
        S_GRAD = 13'b0000000000100,
        S_PROD = 13'b0000000001000,
        S_COLW = 13'b0000000010000,
        S_WRD  = 13'b0000000100000,
        S_WACC = 13'b0000001000000,
        S_MUL  = 13'b0000010000000,
        S_SQR  = 13'b0000100000000,
        S_KMUL = 13'b0001000000000,
        S_KSUM = 13'b0010000000000,
        S_DIFF = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } crs_state_t;

    // ---------------------------------------------------------------------
    // Storage
    // ---------------------------------------------------------------------
    // gray_mem word: {row y-2, row y-1} of the gray image at one column
    logic [2*crs_pkg::PIX_W-1:0] gray_mem [MAX_WIDTH];
    col_word_t                   col_mem  [MAX_WIDTH];

    crs_state_t state_reg, state_next;

    logic [crs_pkg::SENS_W-1:0] sens_reg;
    logic [crs_pkg::FW_W-1:0]   fw_reg;
    logic [crs_pkg::FH_W-1:0]   fh_reg;

    logic [XW-1:0]            col_cnt_reg;
    logic [crs_pkg::ROW_W-1:0] row_cnt_reg;

    // Per-transaction holding registers
    logic [XW-1:0]             x_reg;
    logic [crs_pkg::ROW_W-1:0] y_reg;
    logic [crs_pkg::PIX_W-1:0] gray_reg;
    logic [2*crs_pkg::PIX_W-1:0] gray_rd_reg;
    col_word_t                 col_rd_reg;
    logic [crs_pkg::PIX_W-1:0] gwin_reg [3][3];

    logic signed [crs_pkg::GRAD_W-1:0] ix_reg, iy_reg;
    crs_pkg::prod_t                    prod_reg;

    logic signed [crs_pkg::WSUM_W-1:0] acc_xx_reg, acc_yy_reg, acc_xy_reg;
    logic [IDX_W-1:0]                  win_idx_reg;

    logic [crs_pkg::SQ_W-1:0]          m1_reg, m2_reg, t2_reg;
    logic [crs_pkg::TR_W-1:0]          tr_reg;
    logic signed [crs_pkg::DET_W-1:0]  det_reg;
    logic [crs_pkg::KA_W-1:0]          ka_reg;
    logic [crs_pkg::KB_W-1:0]          kb_reg;
    logic [crs_pkg::KTT_W-1:0]         ktt_reg;
    logic signed [crs_pkg::DIFF_W-1:0] diff_reg;

    logic             out_valid_reg;
    crs_pkg::result_t out_data_reg;

    // ---------------------------------------------------------------------
    // Handshake and frame geometry
    // ---------------------------------------------------------------------
    logic in_take;
    logic out_free;
    logic out_load;

    assign pixel.ready  = (state_reg == S_IDLE);
    assign in_take      = pixel.valid && (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || result.ready;
    assign out_load     = (state_reg == S_OUT) && out_free;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Sizes in use, clamped to the supported range
    logic [SW-1:0] w_use, h_use, fw_ext, fh_ext;
    logic [SW-1:0] cnt_x_ext, cnt_y_ext, x_ext, y_ext;

    assign fw_ext = SW'(fw_reg);
    assign fh_ext = SW'(fh_reg);
    assign w_use  = (fw_ext < SW'(crs_pkg::MIN_SIZE)) ? SW'(crs_pkg::MIN_SIZE) :
                    (fw_ext > SW'(MAX_WIDTH))         ? SW'(MAX_WIDTH) : fw_ext;
    assign h_use  = (fh_ext < SW'(crs_pkg::MIN_SIZE))   ? SW'(crs_pkg::MIN_SIZE) :
                    (fh_ext > SW'(crs_pkg::MAX_HEIGHT)) ? SW'(crs_pkg::MAX_HEIGHT) : fh_ext;

    assign cnt_x_ext = SW'(col_cnt_reg);
    assign cnt_y_ext = SW'(row_cnt_reg);
    assign x_ext     = SW'(x_reg);
    assign y_ext     = SW'(y_reg);

    // Gradient exists once two full rows and columns lie behind the pixel;
    // a response needs the whole summing window inside the frame as well.
    logic grad_ok, win_ok, done_flag;

    assign grad_ok   = (y_ext >= SW'(2)) && (x_ext >= SW'(2));
    assign win_ok    = (y_ext >= SW'(2 * WINDOW_RADIUS + 2))
                    && (x_ext >= SW'(2 * WINDOW_RADIUS + 2))
                    && (x_ext < w_use) && (y_ext < h_use);
    assign done_flag = (x_ext == w_use - SW'(1)) && (y_ext == h_use - SW'(1));

    // Gradient column, one left of the pixel
    logic [XW-1:0] gc;
    assign gc = x_reg - XW'(1);

    // ---------------------------------------------------------------------
    // Gray conversion of the incoming pixel
    // ---------------------------------------------------------------------
    logic [crs_pkg::GRAY_SUM_W-1:0] gray_sum;

    assign gray_sum =
          crs_pkg::GRAY_SUM_W'(crs_pkg::W_BLUE)  * crs_pkg::GRAY_SUM_W'(pixel.data.blue)
        + crs_pkg::GRAY_SUM_W'(crs_pkg::W_GREEN) * crs_pkg::GRAY_SUM_W'(pixel.data.green)
        + crs_pkg::GRAY_SUM_W'(crs_pkg::W_RED)   * crs_pkg::GRAY_SUM_W'(pixel.data.red)
        + crs_pkg::GRAY_SUM_W'(crs_pkg::GRAY_ROUND);

    // ---------------------------------------------------------------------
    // Sobel on the 3x3 gray window (column 0 oldest, row 0 top)
    // ---------------------------------------------------------------------
    logic [crs_pkg::GRAD_W-1:0]        sob_r, sob_l, sob_b, sob_t;
    logic signed [crs_pkg::GRAD_W-1:0] ix_next, iy_next;

    assign sob_r = crs_pkg::GRAD_W'(gwin_reg[0][2]) + (crs_pkg::GRAD_W'(gwin_reg[1][2]) << 1)
                 + crs_pkg::GRAD_W'(gwin_reg[2][2]);
    assign sob_l = crs_pkg::GRAD_W'(gwin_reg[0][0]) + (crs_pkg::GRAD_W'(gwin_reg[1][0]) << 1)
                 + crs_pkg::GRAD_W'(gwin_reg[2][0]);
    assign sob_b = crs_pkg::GRAD_W'(gwin_reg[2][0]) + (crs_pkg::GRAD_W'(gwin_reg[2][1]) << 1)
                 + crs_pkg::GRAD_W'(gwin_reg[2][2]);
    assign sob_t = crs_pkg::GRAD_W'(gwin_reg[0][0]) + (crs_pkg::GRAD_W'(gwin_reg[0][1]) << 1)
                 + crs_pkg::GRAD_W'(gwin_reg[0][2]);
    assign ix_next = $signed(sob_r) - $signed(sob_l);
    assign iy_next = $signed(sob_b) - $signed(sob_t);

    logic signed [2*crs_pkg::GRAD_W-1:0] pxx_full, pyy_full, pxy_full;

    assign pxx_full = ix_reg * ix_reg;
    assign pyy_full = iy_reg * iy_reg;
    assign pxy_full = ix_reg * iy_reg;

    // ---------------------------------------------------------------------
    // Column update: shift the stored products down, add the new row in
    // ---------------------------------------------------------------------
    col_word_t                         col_wr_data;
    logic signed [crs_pkg::CSUM_W-1:0] csum_xx, csum_yy, csum_xy;

    always_comb
    begin
        csum_xx = crs_pkg::CSUM_W'(prod_reg.xx);
        csum_yy = crs_pkg::CSUM_W'(prod_reg.yy);
        csum_xy = crs_pkg::CSUM_W'(prod_reg.xy);
        for (int k = 0; k < PROD_ROWS; k++)
        begin
            csum_xx = csum_xx + crs_pkg::CSUM_W'(col_rd_reg.rows[k].xx);
            csum_yy = csum_yy + crs_pkg::CSUM_W'(col_rd_reg.rows[k].yy);
            csum_xy = csum_xy + crs_pkg::CSUM_W'(col_rd_reg.rows[k].xy);
        end
        col_wr_data.rows[0] = prod_reg;
        for (int k = 1; k < PROD_ROWS; k++)
        begin
            col_wr_data.rows[k] = col_rd_reg.rows[k-1];
        end
        col_wr_data.sxx = csum_xx;
        col_wr_data.syy = csum_yy;
        col_wr_data.sxy = csum_xy;
    end

    // Column memory port control
    logic          col_rd_en;
    logic [XW-1:0] col_rd_addr;
    logic          col_we;

    assign col_we = (state_reg == S_COLW);

    always_comb
    begin
        col_rd_en   = 1'b0;
        col_rd_addr = gc - XW'(win_idx_reg);
        if (in_take)
        begin
            col_rd_en   = 1'b1;
            col_rd_addr = col_cnt_reg - XW'(1);
        end
        else if (state_reg == S_WRD)
        begin
            col_rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[gc] <= col_wr_data;
        end
        if (col_rd_en)
        begin
            col_rd_reg <= col_mem[col_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            gray_mem[x_reg] <= {gray_rd_reg[crs_pkg::PIX_W-1:0], gray_reg};
        end
        if (in_take)
        begin
            gray_rd_reg <= gray_mem[col_cnt_reg];
        end
    end

    // ---------------------------------------------------------------------
    // Harris arithmetic, one multiplier stage per state
    // ---------------------------------------------------------------------
    logic [2*crs_pkg::MAG_W-1:0]         m1_full;
    logic signed [2*crs_pkg::WSUM_W-1:0] m2_full;
    logic [2*crs_pkg::TR_W-1:0]          t2_full;
    logic [crs_pkg::KA_W-1:0]            ka_full;
    logic [crs_pkg::KB_W-1:0]            kb_full;
    logic [crs_pkg::DIFF_W-1:0]          mag;
    logic [crs_pkg::RESP_W-1:0]          resp_sat;

    assign m1_full = acc_xx_reg[crs_pkg::MAG_W-1:0] * acc_yy_reg[crs_pkg::MAG_W-1:0];
    assign m2_full = acc_xy_reg * acc_xy_reg;
    assign t2_full = tr_reg * tr_reg;
    assign ka_full = sens_reg * t2_reg[crs_pkg::SQ_W-1:16];
    assign kb_full = sens_reg * t2_reg[15:0];
    assign mag      = diff_reg[crs_pkg::DIFF_W-1] ? $unsigned(-diff_reg) : $unsigned(diff_reg);
    assign resp_sat = (mag > crs_pkg::DIFF_W'(crs_pkg::RESP_MAX)) ? crs_pkg::RESP_MAX
                                                                  : mag[crs_pkg::RESP_W-1:0];

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_take) state_next = S_READ;
            S_READ: state_next = grad_ok ? S_GRAD : S_IDLE;
            S_GRAD: state_next = S_PROD;
            S_PROD: state_next = S_COLW;
            S_COLW: state_next = win_ok ? S_WRD : S_IDLE;
            S_WRD:  state_next = S_WACC;
            S_WACC: state_next = (win_idx_reg == IDX_W'(SIDE - 1)) ? S_MUL : S_WRD;
            S_MUL:  state_next = S_SQR;
            S_SQR:  state_next = S_KMUL;
            S_KMUL: state_next = S_KSUM;
            S_KSUM: state_next = S_DIFF;
            S_DIFF: state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: FSM, counters, configuration, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sens_reg      <= crs_pkg::SENS_RESET;
            fw_reg        <= crs_pkg::FW_RESET;
            fh_reg        <= crs_pkg::FH_RESET;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            win_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    crs_pkg::REG_SENSITIVITY:  sens_reg <= cfg_data[crs_pkg::SENS_W-1:0];
                    crs_pkg::REG_FRAME_WIDTH:  fw_reg   <= cfg_data[crs_pkg::FW_W-1:0];
                    crs_pkg::REG_FRAME_HEIGHT: fh_reg   <= cfg_data[crs_pkg::FH_W-1:0];
                    default: ;
                endcase
            end

            // Raster position moves on as soon as the pixel is taken
            if (in_take)
            begin
                if (cnt_x_ext + SW'(1) >= w_use)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= (cnt_y_ext + SW'(1) >= h_use) ? '0
                                 : row_cnt_reg + crs_pkg::ROW_W'(1);
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + XW'(1);
                end
            end

            if (state_reg == S_COLW)
            begin
                win_idx_reg <= '0;
            end
            else if (state_reg == S_WACC)
            begin
                win_idx_reg <= win_idx_reg + IDX_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg    <= col_cnt_reg;
            y_reg    <= row_cnt_reg;
            gray_reg <= gray_sum[crs_pkg::GRAY_SHIFT +: crs_pkg::PIX_W];
        end

        if (state_reg == S_READ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                gwin_reg[i][0] <= gwin_reg[i][1];
                gwin_reg[i][1] <= gwin_reg[i][2];
            end
            gwin_reg[0][2] <= gray_rd_reg[2*crs_pkg::PIX_W-1:crs_pkg::PIX_W];
            gwin_reg[1][2] <= gray_rd_reg[crs_pkg::PIX_W-1:0];
            gwin_reg[2][2] <= gray_reg;
        end

        if (state_reg == S_GRAD)
        begin
            ix_reg <= ix_next;
            iy_reg <= iy_next;
        end

        if (state_reg == S_PROD)
        begin
            prod_reg.xx <= crs_pkg::PROD_W'(pxx_full);
            prod_reg.yy <= crs_pkg::PROD_W'(pyy_full);
            prod_reg.xy <= crs_pkg::PROD_W'(pxy_full);
        end

        if (state_reg == S_COLW)
        begin
            acc_xx_reg <= '0;
            acc_yy_reg <= '0;
            acc_xy_reg <= '0;
        end
        else if (state_reg == S_WACC)
        begin
            acc_xx_reg <= acc_xx_reg + crs_pkg::WSUM_W'(col_rd_reg.sxx);
            acc_yy_reg <= acc_yy_reg + crs_pkg::WSUM_W'(col_rd_reg.syy);
            acc_xy_reg <= acc_xy_reg + crs_pkg::WSUM_W'(col_rd_reg.sxy);
        end

        if (state_reg == S_MUL)
        begin
            m1_reg <= crs_pkg::SQ_W'(m1_full);
            m2_reg <= m2_full[crs_pkg::SQ_W-1:0];
            tr_reg <= crs_pkg::TR_W'(acc_xx_reg[crs_pkg::MAG_W-1:0])
                    + crs_pkg::TR_W'(acc_yy_reg[crs_pkg::MAG_W-1:0]);
        end

        if (state_reg == S_SQR)
        begin
            t2_reg  <= t2_full;
            det_reg <= $signed(crs_pkg::DET_W'(m1_reg)) - $signed(crs_pkg::DET_W'(m2_reg));
        end

        if (state_reg == S_KMUL)
        begin
            ka_reg <= ka_full;
            kb_reg <= kb_full;
        end

        // floor(k * trace^2 / 2^16), split at bit 16 of trace^2
        if (state_reg == S_KSUM)
        begin
            ktt_reg <= crs_pkg::KTT_W'(ka_reg) + crs_pkg::KTT_W'(kb_reg[crs_pkg::KB_W-1:16]);
        end

        if (state_reg == S_DIFF)
        begin
            diff_reg <= crs_pkg::DIFF_W'(det_reg) - $signed({2'b00, ktt_reg});
        end

        if (out_load)
        begin
            out_data_reg.center_row    <= y_reg - crs_pkg::ROW_W'(WINDOW_RADIUS + 1);
            out_data_reg.center_column <= crs_pkg::COLO_W'(x_ext - SW'(WINDOW_RADIUS + 1));
            out_data_reg.response      <= resp_sat;
            out_data_reg.frame_done    <= done_flag;
        end
    end

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `CRS_ASSERT_NEXT(a_take_reads, in_take, state_reg == S_READ, "taken pixel did not start a read")
    `CRS_ASSERT_NEXT(a_border_skip, (state_reg == S_READ) && !grad_ok, state_reg == S_IDLE, "border pixel did work")
    `CRS_ASSERT_IMPL(a_win_index, state_reg == S_WACC, win_idx_reg < IDX_W'(SIDE), "window index past window")
    `CRS_ASSERT_IMPL(a_result_src, $rose(out_valid_reg), $past(state_reg == S_OUT), "result without response")

endmodule

`default_nettype wire

// ===== dv/corner_response_stream_test.sv =====
// Self-checking testbench for the corner response stream block.
`timescale 1ns / 100ps

module corner_response_stream_test;

    localparam int LINE_MAX  = 1024;
    localparam int DRAIN_CYC = 60;   // well past one response's worth of pipeline

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [crs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [crs_pkg::CFG_DATA_W-1:0] cfg_data;

    crs_pixel_if  pix ();
    crs_result_if res ();

    corner_response_stream DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's state
    int unsigned k_sens;
    int unsigned width_reg;
    int unsigned height_reg;
    byte unsigned gray_lines [2][LINE_MAX];
    int prod_xx [2][LINE_MAX];
    int prod_yy [2][LINE_MAX];
    int prod_xy [2][LINE_MAX];
    int colsum_xx [LINE_MAX];
    int colsum_yy [LINE_MAX];
    int colsum_xy [LINE_MAX];
    int gwin [3][3];
    int unsigned row_cnt;
    int unsigned col_cnt;

    crs_pkg::result_t expected_responses [$];
    int      error_count;
    int      send_idle_pct;
    int      recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        return (v < crs_pkg::MIN_SIZE) ? crs_pkg::MIN_SIZE : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [crs_pkg::RESP_W-1:0] harris_response(longint sxx, longint syy,
                                                                    longint sxy);
        longint          det;
        longint unsigned tr;
        longint unsigned t2;
        longint unsigned ktt;
        longint          diff;
        longint unsigned mag;
        det  = sxx * syy - sxy * sxy;
        tr   = longint'(sxx + syy);
        t2   = tr * tr;
        ktt  = k_sens * (t2 >> 16) + ((k_sens * (t2 & 64'hFFFF)) >> 16);
        diff = det - longint'(ktt);
        mag  = (diff < 0) ? longint'(-diff) : diff;
        return (mag > crs_pkg::RESP_MAX) ? crs_pkg::RESP_MAX : mag[crs_pkg::RESP_W-1:0];
    endfunction

    // Advance the shadow state by one accepted pixel; queue the response if any
    function automatic void track_pixel(crs_pkg::pixel_t p);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned gc;
        int gray;
        int top;
        int mid;
        int ix;
        int iy;
        int pxx;
        int pyy;
        int pxy;
        longint sxx;
        longint syy;
        longint sxy;
        crs_pkg::result_t r;
        w = clamp_size(width_reg, LINE_MAX);
        h = clamp_size(height_reg, crs_pkg::MAX_HEIGHT);
        x = col_cnt;
        y = row_cnt;
        gray = (crs_pkg::W_BLUE * p.blue + crs_pkg::W_GREEN * p.green
                + crs_pkg::W_RED * p.red + crs_pkg::GRAY_ROUND) >> crs_pkg::GRAY_SHIFT;
        top = gray_lines[1][x];
        mid = gray_lines[0][x];
        gray_lines[1][x] = mid;
        gray_lines[0][x] = gray;
        for (int i = 0; i < 3; i++)
        begin
            gwin[i][0] = gwin[i][1];
            gwin[i][1] = gwin[i][2];
        end
        gwin[0][2] = top;
        gwin[1][2] = mid;
        gwin[2][2] = gray;

        if (y >= 2 && x >= 2)
        begin
            gc = x - 1;
            ix = (gwin[0][2] + 2 * gwin[1][2] + gwin[2][2])
               - (gwin[0][0] + 2 * gwin[1][0] + gwin[2][0]);
            iy = (gwin[2][0] + 2 * gwin[2][1] + gwin[2][2])
               - (gwin[0][0] + 2 * gwin[0][1] + gwin[0][2]);
            pxx = ix * ix;
            pyy = iy * iy;
            pxy = ix * iy;
            colsum_xx[gc] = pxx + prod_xx[0][gc] + prod_xx[1][gc];
            colsum_yy[gc] = pyy + prod_yy[0][gc] + prod_yy[1][gc];
            colsum_xy[gc] = pxy + prod_xy[0][gc] + prod_xy[1][gc];
            prod_xx[1][gc] = prod_xx[0][gc];
            prod_yy[1][gc] = prod_yy[0][gc];
            prod_xy[1][gc] = prod_xy[0][gc];
            prod_xx[0][gc] = pxx;
            prod_yy[0][gc] = pyy;
            prod_xy[0][gc] = pxy;

            // interior centre: whole 5x5 neighbourhood inside the frame
            if (y >= 4 && x >= 4 && x < w && y < h)
            begin
                sxx = 0;
                syy = 0;
                sxy = 0;
                for (int j = 0; j < 3; j++)
                begin
                    sxx += colsum_xx[gc - j];
                    syy += colsum_yy[gc - j];
                    sxy += colsum_xy[gc - j];
                end
                r.center_row    = crs_pkg::ROW_W'(y - 2);
                r.center_column = crs_pkg::COLO_W'(x - 2);
                r.response      = harris_response(sxx, syy, sxy);
                r.frame_done    = (x == w - 1 && y == h - 1);
                expected_responses.insert(expected_responses.size(), r);
            end
        end

        if (x + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col_cnt = x + 1;
        end
    endfunction

    // Response checker and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("unexpected response row %0d col %0d",
                       res.data.center_row, res.data.center_column);
                error_count++;
            end
            else
            begin
                crs_pkg::result_t e;
                e = expected_responses.pop_front();
                if (res.data.center_row !== e.center_row)
                begin
                    $error("center_row: expected %0d, got %0d", e.center_row,
                           res.data.center_row);
                    error_count++;
                end
                if (res.data.center_column !== e.center_column)
                begin
                    $error("center_column: expected %0d, got %0d", e.center_column,
                           res.data.center_column);
                    error_count++;
                end
                if (res.data.response !== e.response)
                begin
                    $error("response: expected %0d, got %0d", e.response,
                           res.data.response);
                    error_count++;
                end
                if (res.data.frame_done !== e.frame_done)
                begin
                    $error("frame_done: expected %0d, got %0d", e.frame_done,
                           res.data.frame_done);
                    error_count++;
                end
            end
        end
        res.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // One pixel transaction; valid stays high unless a gap follows
    task automatic send_pixel(crs_pkg::pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.data  <= p;
        do
            @(posedge clk);
        while (!pix.ready);
        track_pixel(p);
    endtask

    // Drop valid and let the block drain completely
    task automatic wait_idle();
        pix.valid <= 1'b0;
        wait (expected_responses.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Write enable is left high; the caller drops it after the last write
    task automatic write_reg(crs_pkg::cfg_reg_t idx, int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= crs_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            crs_pkg::REG_SENSITIVITY:  k_sens     = value & 16'hFFFF;
            crs_pkg::REG_FRAME_WIDTH:  width_reg  = value & 11'h7FF;
            crs_pkg::REG_FRAME_HEIGHT: height_reg = value & 13'h1FFF;
            default: ;
        endcase
    endtask

    task automatic set_frame(int unsigned k, int unsigned w, int unsigned h);
        wait_idle();
        write_reg(crs_pkg::REG_SENSITIVITY, k);
        write_reg(crs_pkg::REG_FRAME_WIDTH, w);
        write_reg(crs_pkg::REG_FRAME_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    function automatic crs_pkg::pixel_t random_pixel();
        crs_pkg::pixel_t p;
        p.blue  = $urandom;
        p.green = $urandom;
        p.red   = $urandom;
        return p;
    endfunction

    task automatic send_random_frame();
        int unsigned n;
        n = clamp_size(width_reg, LINE_MAX) * clamp_size(height_reg, crs_pkg::MAX_HEIGHT);
        for (int i = 0; i < n; i++)
            send_pixel(random_pixel());
    endtask

    // Edge and corner shapes at full swing, then flat black and flat white
    task automatic test_extreme_patterns();
        crs_pkg::pixel_t p;
        set_frame(0, 8, 8);
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
            begin
                p = ((x < 4) ^ (y < 4)) ? {8'hFF, 8'hFF, 8'hFF} : '0;
                send_pixel(p);
            end
        set_frame(65535, 8, 8);
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
            begin
                p = (x == y) ? {8'hFF, 8'h00, 8'hFF} : {8'h00, 8'hFF, 8'h00};
                send_pixel(p);
            end
        for (int i = 0; i < 64; i++)
            send_pixel('0);
        for (int i = 0; i < 64; i++)
            send_pixel({8'hFF, 8'hFF, 8'hFF});
    endtask

    // Size registers below and above their usable range are clamped
    task automatic test_clamped_sizes();
        set_frame($urandom_range(65535), 3, 5);
        send_random_frame();
        // widest line, 2047 clamps to the full line buffer: one whole line and
        // the start of the next, then a small frame carries on from there
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_frame(2621, 2047, 0);
        for (int i = 0; i < LINE_MAX + 8; i++)
            send_pixel(random_pixel());
        set_frame(2621, 8, 8);
        send_random_frame();
    endtask

    // Random frames under one idling pattern
    task automatic test_random_frames(int send_pct, int recv_pct, int target);
        int sent;
        sent = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (sent < target)
        begin
            set_frame($urandom_range(1) ? $urandom_range(65535) : 2621,
                      $urandom_range(8, 10), 8);
            send_random_frame();
            sent += width_reg * height_reg;
        end
    endtask

    // Sender holds off mid-frame until every response is out
    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        set_frame(1000, 12, 8);
        for (int i = 0; i < 96; i++)
        begin
            if (i == 50)
            begin
                pix.valid <= 1'b0;
                wait (expected_responses.size() == 0);
                @(posedge clk);
            end
            send_pixel(random_pixel());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pix.valid      = 1'b0;
        pix.data       = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        k_sens         = crs_pkg::SENS_RESET;
        width_reg      = crs_pkg::FW_RESET;
        height_reg     = crs_pkg::FH_RESET;
        row_cnt        = 0;
        col_cnt        = 0;
        gwin           = '{default: 0};
        colsum_xx      = '{default: 0};
        colsum_yy      = '{default: 0};
        colsum_xy      = '{default: 0};
        prod_xx        = '{default: 0};
        prod_yy        = '{default: 0};
        prod_xy        = '{default: 0};
        gray_lines     = '{default: 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_patterns();
        test_sender_pause();
        test_random_frames(0, 0, 60);
        test_random_frames(85, 0, 60);
        test_random_frames(0, 85, 60);
        test_random_frames(34, 34, 60);
        test_clamped_sizes();

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
